// ===== rtl/banked_register_file_irq_entry_defines.svh =====
// Assertion macros used by the checker of the register file.
`ifndef BANKED_REGISTER_FILE_IRQ_ENTRY_DEFINES_SVH
`define BANKED_REGISTER_FILE_IRQ_ENTRY_DEFINES_SVH

// A property checked at every rising clock edge outside reset.
`define BRF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A same-cycle implication checked outside reset.
`define BRF_ASSERT_IMPLIES(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) else $error(msg);

`endif

// ===== rtl/brf_pkg.sv =====
package brf_pkg;

  localparam int unsigned NumWords = 43;
  localparam int unsigned AddrW    = 6;
  localparam int unsigned StepW    = 5;

  // Word layout of the state memory.
  localparam logic [AddrW-1:0] VisBase  = 6'd0;
  localparam logic [AddrW-1:0] VisR8    = 6'd8;
  localparam logic [AddrW-1:0] VisR13   = 6'd13;
  localparam logic [AddrW-1:0] VisR14   = 6'd14;
  localparam logic [AddrW-1:0] VisR15   = 6'd15;
  localparam logic [AddrW-1:0] BankBase = 6'd16;
  localparam logic [AddrW-1:0] FiqBase  = 6'd28;
  localparam logic [AddrW-1:0] UsrBase  = 6'd33;
  localparam logic [AddrW-1:0] SprBase  = 6'd38;

  localparam logic [StepW-1:0] StepFiqOut = 5'd10;
  localparam logic [StepW-1:0] StepSave   = 5'd12;
  localparam logic [StepW-1:0] StepFiqIn  = 5'd22;
  localparam logic [StepW-1:0] StepLast   = 5'd23;

  localparam logic [4:0]  MODE_USR = 5'h10;
  localparam logic [4:0]  MODE_FIQ = 5'h11;
  localparam logic [4:0]  MODE_IRQ = 5'h12;
  localparam logic [4:0]  MODE_SVC = 5'h13;
  localparam logic [4:0]  MODE_ABT = 5'h17;
  localparam logic [4:0]  MODE_UND = 5'h1B;
  localparam logic [4:0]  MODE_SYS = 5'h1F;
  localparam logic [2:0]  SlotIrq  = 3'd3;
  localparam logic [31:0] IrqVector = 32'h0000_0018;
  localparam logic [31:0] StatusReset = 32'h0000_0013;

  typedef enum logic [2:0] {
    OP_READ_REG     = 3'd0,
    OP_WRITE_REG    = 3'd1,
    OP_WRITE_STATUS = 3'd2,
    OP_READ_SAVED   = 3'd3,
    OP_WRITE_SAVED  = 3'd4,
    OP_IRQ_CHECK    = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_COPY_RD,
    ST_COPY_WR,
    ST_IRQ_RD,
    ST_IRQ_LR,
    ST_IRQ_PC,
    ST_PUT
  } st_e;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [3:0]  reg_index;
    logic [31:0] write_data;
    logic        irq_pending;
    logic        irq_master_enable;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic [31:0] status_word;
    logic        irq_taken;
    logic        pc_written;
  } out_item_t;

  typedef struct packed {
    logic             en;
    logic [AddrW-1:0] src;
    logic [AddrW-1:0] dst;
  } copy_t;

  typedef struct packed {
    logic       hit;
    logic [2:0] idx;
  } slot_t;

  function automatic logic [2:0] bank_of(logic [4:0] mode);
    logic [2:0] b;
    case (mode)
      MODE_FIQ: b = 3'd1;
      MODE_IRQ: b = 3'd2;
      MODE_SVC: b = 3'd3;
      MODE_ABT: b = 3'd4;
      MODE_UND: b = 3'd5;
      default:  b = 3'd0;
    endcase
    return b;
  endfunction

  function automatic slot_t saved_slot(logic [4:0] mode);
    slot_t s;
    s.hit = 1'b1;
    case (mode)
      MODE_FIQ: s.idx = 3'd0;
      MODE_SVC: s.idx = 3'd1;
      MODE_ABT: s.idx = 3'd2;
      MODE_IRQ: s.idx = SlotIrq;
      MODE_UND: s.idx = 3'd4;
      default: begin
        s.hit = 1'b0;
        s.idx = 3'd0;
      end
    endcase
    return s;
  endfunction

  // User and system modes share a bank, so a move between them swaps nothing.
  function automatic logic swap_needed(logic [4:0] old_mode, logic [4:0] new_mode);
    return (old_mode != new_mode) &&
           !((old_mode == MODE_USR) && (new_mode == MODE_SYS)) &&
           !((old_mode == MODE_SYS) && (new_mode == MODE_USR));
  endfunction

  function automatic logic [AddrW-1:0] bank_addr(logic [2:0] b, logic second);
    return BankBase + {2'b00, b, second};
  endfunction

  // One word move of a bank swap. Steps run in the order: leave the fast
  // interrupt bank, save SP/LR, enter the fast interrupt bank, load SP/LR.
  function automatic copy_t copy_step(logic [StepW-1:0] step, logic [4:0] old_mode,
                                      logic [4:0] new_mode);
    copy_t      c;
    logic [StepW-1:0] rel;
    logic [2:0] k;
    c   = '0;
    rel = step - StepSave;
    k   = 3'd0;
    if (step < StepFiqOut) begin
      k    = step[3:1];
      c.en = (old_mode == MODE_FIQ);
      if (!step[0]) begin
        c.src = VisR8 + AddrW'(k);
        c.dst = FiqBase + AddrW'(k);
      end else begin
        c.src = UsrBase + AddrW'(k);
        c.dst = VisR8 + AddrW'(k);
      end
    end else if (step < StepSave) begin
      c.en  = 1'b1;
      c.src = step[0] ? VisR14 : VisR13;
      c.dst = bank_addr(bank_of(old_mode), step[0]);
    end else if (step < StepFiqIn) begin
      k    = rel[3:1];
      c.en = (new_mode == MODE_FIQ);
      if (!step[0]) begin
        c.src = VisR8 + AddrW'(k);
        c.dst = UsrBase + AddrW'(k);
      end else begin
        c.src = FiqBase + AddrW'(k);
        c.dst = VisR8 + AddrW'(k);
      end
    end else begin
      c.en  = 1'b1;
      c.src = bank_addr(bank_of(new_mode), step[0]);
      c.dst = step[0] ? VisR14 : VisR13;
    end
    return c;
  endfunction

endpackage

// ===== rtl/brf_if.sv =====
interface brf_in_if import brf_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface brf_out_if import brf_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/banked_register_file_irq_entry.sv =====
// Mode-banked register file with interrupt entry.
// in_i carries one operation per transfer (register read or write, status
// write, saved status read or write, interrupt check); out_o returns exactly
// one result per operation, in order. All register, bank and saved status
// words live in one 43-word memory with a registered read port, so every
// word move is a read followed by a write.
// A status write with a bank swap walks the sequencer through 24 steps,
// each either a word move or skipped when its move is not needed, and
// interrupt entry adds the IRQ_RD, IRQ_LR and IRQ_PC states after any swap.
// The next operation is taken once the current one has handed its result to
// the output register, which may still be waiting for the receiver. While
// the receiver stalls, the result and its valid stay unchanged, and at most
// one further result is held inside before input stops.
// Reset puts the block in supervisor mode with every word reading as zero.
module banked_register_file_irq_entry import brf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  brf_in_if.sink    in_i,
  brf_out_if.source out_o
);

  logic [31:0] mem [NumWords];
  logic [31:0] rdata_q;
  logic        rvld_q;
  logic [NumWords-1:0] vld_q;

  logic             mem_we, mem_re;
  logic [AddrW-1:0] mem_waddr, mem_raddr;
  logic [31:0]      mem_wdata, rd_eff;

  st_e state_q, state_d;
  logic [2:0]  op_q, op_d;
  logic [31:0] old_q, old_d;
  logic [31:0] status_q, status_d;
  logic [StepW-1:0] step_q, step_d;
  logic [4:0]  oldm_q, oldm_d, newm_q, newm_d;
  logic [31:0] rd_q, rd_d;
  logic        taken_q, taken_d, pcw_q, pcw_d;
  logic        out_valid_q;
  out_item_t   out_q;

  in_item_t p;
  logic     in_acc, put_go, irq_due;
  slot_t    slot;
  copy_t    cp;
  st_e      done_st;

  assign p         = in_i.payload;
  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc    = in_i.valid && in_i.ready;
  assign put_go    = (state_q == ST_PUT) && (!out_valid_q || out_o.ready);
  assign slot      = saved_slot(status_q[4:0]);
  assign cp        = copy_step(step_q, oldm_q, newm_q);
  assign irq_due   = !status_q[7] && p.irq_pending && p.irq_master_enable;
  assign rd_eff    = rvld_q ? rdata_q : '0;
  assign done_st   = taken_q ? ST_IRQ_RD : ST_PUT;

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (p.opcode)
            OP_READ_REG:     state_d = ST_READ;
            OP_READ_SAVED:   state_d = slot.hit ? ST_READ : ST_PUT;
            OP_WRITE_STATUS: begin
              state_d = swap_needed(status_q[4:0], p.write_data[4:0]) ? ST_COPY_RD : ST_PUT;
            end
            OP_IRQ_CHECK: begin
              if (irq_due) begin
                state_d = swap_needed(status_q[4:0], MODE_IRQ) ? ST_COPY_RD : ST_IRQ_RD;
              end else begin
                state_d = ST_PUT;
              end
            end
            default:         state_d = ST_PUT;
          endcase
        end
      end
      ST_READ:    state_d = ST_PUT;
      ST_COPY_RD: begin
        if (cp.en) begin
          state_d = ST_COPY_WR;
        end else if (step_q == StepLast) begin
          state_d = done_st;
        end
      end
      ST_COPY_WR: state_d = (step_q == StepLast) ? done_st : ST_COPY_RD;
      ST_IRQ_RD:  state_d = ST_IRQ_LR;
      ST_IRQ_LR:  state_d = ST_IRQ_PC;
      ST_IRQ_PC:  state_d = ST_PUT;
      ST_PUT:     if (put_go) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // Memory accesses and datapath updates.
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = VisBase;
    mem_raddr = VisBase;
    mem_wdata = '0;
    op_d      = op_q;
    old_d     = old_q;
    status_d  = status_q;
    step_d    = step_q;
    oldm_d    = oldm_q;
    newm_d    = newm_q;
    rd_d      = rd_q;
    taken_d   = taken_q;
    pcw_d     = pcw_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          op_d    = p.opcode;
          rd_d    = '0;
          taken_d = 1'b0;
          pcw_d   = 1'b0;
          step_d  = '0;
          oldm_d  = status_q[4:0];
          case (p.opcode)
            OP_READ_REG: begin
              mem_re    = 1'b1;
              mem_raddr = VisBase + AddrW'(p.reg_index);
            end
            OP_WRITE_REG: begin
              mem_we    = 1'b1;
              mem_waddr = VisBase + AddrW'(p.reg_index);
              mem_wdata = p.write_data;
              pcw_d     = (p.reg_index == 4'd15);
            end
            OP_WRITE_STATUS: begin
              status_d = p.write_data;
              newm_d   = p.write_data[4:0];
            end
            OP_READ_SAVED: begin
              if (slot.hit) begin
                mem_re    = 1'b1;
                mem_raddr = SprBase + AddrW'(slot.idx);
              end else begin
                rd_d = status_q;
              end
            end
            OP_WRITE_SAVED: begin
              if (slot.hit) begin
                mem_we    = 1'b1;
                mem_waddr = SprBase + AddrW'(slot.idx);
                mem_wdata = p.write_data;
              end
            end
            OP_IRQ_CHECK: begin
              if (irq_due) begin
                old_d    = status_q;
                status_d = {status_q[31:8], 1'b1, status_q[6], 1'b0, MODE_IRQ};
                newm_d   = MODE_IRQ;
                taken_d  = 1'b1;
                pcw_d    = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_READ: rd_d = rd_eff;
      ST_COPY_RD: begin
        if (cp.en) begin
          mem_re    = 1'b1;
          mem_raddr = cp.src;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      ST_COPY_WR: begin
        mem_we    = 1'b1;
        mem_waddr = cp.dst;
        mem_wdata = rd_eff;
        step_d    = step_q + 1'b1;
      end
      ST_IRQ_RD: begin
        // Fetch the old PC while the old status goes to the IRQ saved slot.
        mem_re    = 1'b1;
        mem_raddr = VisR15;
        mem_we    = 1'b1;
        mem_waddr = SprBase + AddrW'(SlotIrq);
        mem_wdata = old_q;
      end
      ST_IRQ_LR: begin
        mem_we    = 1'b1;
        mem_waddr = VisR14;
        mem_wdata = old_q[5] ? rd_eff : rd_eff - 32'd4;
      end
      ST_IRQ_PC: begin
        mem_we    = 1'b1;
        mem_waddr = VisR15;
        mem_wdata = IrqVector;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_q <= mem[mem_raddr];
  end

  // A word that has never been written reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (mem_we) vld_q[mem_waddr] <= 1'b1;
      if (mem_re) rvld_q <= vld_q[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      status_q    <= StatusReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
      if (put_go) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    old_q   <= old_d;
    step_q  <= step_d;
    oldm_q  <= oldm_d;
    newm_q  <= newm_d;
    rd_q    <= rd_d;
    taken_q <= taken_d;
    pcw_q   <= pcw_d;
    if (put_go) begin
      out_q.read_data   <= (op_q == OP_READ_REG || op_q == OP_READ_SAVED) ? rd_q : '0;
      out_q.status_word <= status_q;
      out_q.irq_taken   <= taken_q;
      out_q.pc_written  <= pcw_q;
    end
  end

endmodule

// ===== rtl/brf_checker.sv =====
`include "banked_register_file_irq_entry_defines.svh"

module brf_checker import brf_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_i,
  input logic      out_valid_i,
  input logic      out_ready_i,
  input out_item_t out_payload_i
);

  logic in_xfer, out_stall;

  assign in_xfer   = in_valid_i && in_ready_i;
  assign out_stall = out_valid_i && !out_ready_i;

  `BRF_ASSERT(a_out_hold, out_stall |=> out_valid_i && $stable(out_payload_i), "result changed while stalled")
  `BRF_ASSERT(a_one_at_a_time, in_xfer |=> !in_ready_i, "operation taken while another is in progress")
  `BRF_ASSERT_IMPLIES(a_irq_flush, out_valid_i && out_payload_i.irq_taken, out_payload_i.pc_written, "interrupt entry without flush")
  `BRF_ASSERT_IMPLIES(a_irq_mode, out_valid_i && out_payload_i.irq_taken, out_payload_i.status_word[4:0] == MODE_IRQ && out_payload_i.status_word[7] && !out_payload_i.status_word[5], "interrupt entry left wrong status")

endmodule

bind banked_register_file_irq_entry brf_checker u_brf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_payload_i (out_o.payload)
);
